// ===== sv/slet_pkg.sv =====
`timescale 1ns / 1ps

package slet_pkg;

	// Line store geometry
	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = 8;

	// Special input bytes
	localparam logic [BW-1:0] CH_CR  = 8'd13;
	localparam logic [BW-1:0] CH_LF  = 8'd10;
	localparam logic [BW-1:0] CH_BS  = 8'd8;
	localparam logic [BW-1:0] CH_DEL = 8'd127;
	localparam logic [BW-1:0] CH_NUL = 8'd0;
	localparam logic [BW-1:0] CH_SP  = 8'd32;
	localparam logic [BW-1:0] CH_TAB = 8'd9;

	// Register map
	localparam int            CFG_DW        = 32;
	localparam int            CFG_AW        = 3;
	localparam logic          REG_OUT_LIMIT = 1'b0;
	localparam logic [BW-1:0] OUT_LIMIT_RST = 8'd63;

	// Store access request, one write and one read port
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [BW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

	// Space, tab, LF, VT, FF, CR
	function automatic logic is_blank(input logic [BW-1:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== sv/slet_if.sv =====
`timescale 1ns / 1ps

// Received byte channel
interface slet_rx_if;
	import slet_pkg::*;
	logic          valid;
	logic          ready;
	logic [BW-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Trimmed line channel
interface slet_line_if;
	import slet_pkg::*;
	logic          valid;
	logic          ready;
	logic [BW-1:0] line_char;
	logic          line_last;
	logic          line_empty;
	modport source (output valid, output line_char, output line_last, output line_empty,
		input ready);
	modport sink   (input valid, input line_char, input line_last, input line_empty,
		output ready);
endinterface

// ===== sv/serial_line_editor_trim.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                  Handshake
// rx       in   rx_byte[7:0]                             valid/ready
// line     out  line_char[7:0], line_last, line_empty    valid/ready
// apb      in   paddr[2:0], pwdata[31:0] -> prdata       psel/penable, pready tied high
//
// An edit byte (store, backspace, delete, ignored terminator) leaves the block idle.
// A line end scans the store up to min(fill, out_limit) or the first zero byte, with
// a read and a check state per character, then emits each character through a read
// and a load state; the single read port of the line store sets this pace. Output stalls hold the load state.
// Reset: out_limit 63, fill count zero; the store itself is not cleared.
// A new byte is taken once the last result of a line sits in the output register.

module serial_line_editor_trim
	import slet_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	output logic                pready,
	slet_rx_if.sink             rx,
	slet_line_if.source         line
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN_RD  = 3'd1;
	localparam logic [2:0] ST_SCAN_CHK = 3'd2;
	localparam logic [2:0] ST_EMIT_RD  = 3'd3;
	localparam logic [2:0] ST_EMIT_LD  = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	logic [2:0]    state_q;
	logic [BW-1:0] out_limit_q;
	logic [AW-1:0] fill_q;
	logic [AW-1:0] lim_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] last_q;
	logic          found_q;
	logic          out_v_q;
	logic [BW-1:0] out_char_q;
	logic          out_last_q;
	logic          out_empty_q;

	mem_req_t      req;
	logic [BW-1:0] rdata;
	logic          rx_take;
	logic          is_term;
	logic          is_erase;
	logic          out_free;
	logic [AW-1:0] lim_next;

	// Config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUT_LIMIT) ? CFG_DW'(out_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= OUT_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUT_LIMIT)) begin
			out_limit_q <= pwdata[BW-1:0];
		end
	end

	// Input decode
	assign rx.ready = (state_q == ST_IDLE);
	assign rx_take  = rx.valid && rx.ready;
	assign is_term  = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
	assign is_erase = (rx.rx_byte == CH_BS) || (rx.rx_byte == CH_DEL);
	assign out_free = !out_v_q || line.ready;
	assign lim_next = ({{(BW-AW){1'b0}}, fill_q} <= out_limit_q) ? fill_q
		: out_limit_q[AW-1:0];

	// Store requests
	always_comb begin
		req.we    = rx_take && !is_term && !is_erase && (fill_q != AW'(DEPTH - 1));
		req.waddr = fill_q;
		req.wdata = rx.rx_byte;
		req.re    = ((state_q == ST_SCAN_RD) && (idx_q != lim_q)) || (state_q == ST_EMIT_RD);
		req.raddr = (state_q == ST_EMIT_RD) ? first_q : idx_q;
	end

	slet_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			lim_q   <= '0;
			idx_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rx_take) begin
						if (is_term) begin
							if (fill_q != '0) begin
								lim_q   <= lim_next;
								idx_q   <= '0;
								found_q <= 1'b0;
								fill_q  <= '0;
								state_q <= ST_SCAN_RD;
							end
						end else if (is_erase) begin
							if (fill_q != '0) begin
								fill_q <= fill_q - AW'(1);
							end
						end else if (req.we) begin
							fill_q <= fill_q + AW'(1);
						end
					end
				end
				ST_SCAN_RD: begin
					if (idx_q == lim_q) begin
						state_q <= found_q ? ST_EMIT_RD : ST_EMPTY;
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					// a zero byte ends the text
					if (rdata == CH_NUL) begin
						state_q <= found_q ? ST_EMIT_RD : ST_EMPTY;
					end else begin
						if (!is_blank(rdata)) begin
							if (!found_q) begin
								first_q <= idx_q;
							end
							found_q <= 1'b1;
							last_q  <= idx_q + AW'(1);
						end
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						first_q <= first_q + AW'(1);
						state_q <= ((first_q + AW'(1)) == last_q) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (((state_q == ST_EMIT_LD) || (state_q == ST_EMPTY)) && out_free) begin
			out_v_q <= 1'b1;
		end else if (line.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT_LD) && out_free) begin
			out_char_q  <= rdata;
			out_last_q  <= ((first_q + AW'(1)) == last_q);
			out_empty_q <= 1'b0;
		end else if ((state_q == ST_EMPTY) && out_free) begin
			out_char_q  <= CH_NUL;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end
	end

	assign line.valid      = out_v_q;
	assign line.line_char  = out_char_q;
	assign line.line_last  = out_last_q;
	assign line.line_empty = out_empty_q;

endmodule

// ===== sv/slet_store.sv =====
`timescale 1ns / 1ps

module slet_store
	import slet_pkg::*;
(
	input  logic          clk,
	input  mem_req_t      req,
	output logic [BW-1:0] rdata
);

	logic [BW-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== sv/slet_chk.sv =====
`timescale 1ns / 1ps

module slet_chk
	import slet_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          rx_ready,
	input logic          line_valid,
	input logic          line_ready,
	input logic [BW-1:0] line_char,
	input logic          line_last,
	input logic          line_empty
);

	// A stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=> line_valid)
		else $error("result dropped while stalled");

	// A blank line is a single closing item with a zero character
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && line_empty |-> line_last && (line_char == CH_NUL))
		else $error("empty result not closing the line");

	// No new byte is taken while a line is still being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_last |-> !rx_ready)
		else $error("input taken in the middle of a line");

	// A stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=> $stable(line_char) && $stable(line_last)
			&& $stable(line_empty))
		else $error("result changed while stalled");

endmodule

bind serial_line_editor_trim slet_chk u_slet_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_ready   (rx.ready),
	.line_valid (line.valid),
	.line_ready (line.ready),
	.line_char  (line.line_char),
	.line_last  (line.line_last),
	.line_empty (line.line_empty)
);

// ===== tb/sv/serial_line_editor_trim_test.sv =====
`timescale 1ns / 1ps

module serial_line_editor_trim_test;
	import slet_pkg::*;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
	localparam int HOLD_CYCLES   = 600;
	localparam int MAX_REPORTS   = 10;

	localparam logic [BW-1:0]     CH_VT          = 8'd11;
	localparam logic [BW-1:0]     CH_FF          = 8'd12;
	localparam logic [CFG_AW-1:0] OUT_LIMIT_ADDR = CFG_AW'({REG_OUT_LIMIT, 2'b00});

	// One character of a trimmed line as it should leave the block
	typedef struct {
		logic [BW-1:0] ch;
		logic          last;
		logic          empty;
	} line_item_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	slet_rx_if   rx_ch ();
	slet_line_if line_ch ();

	serial_line_editor_trim dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.line    (line_ch)
	);

	// Shadow copy of the line buffer, its fill and the output limit
	logic [BW-1:0] line_copy [DEPTH];
	int unsigned   fill_copy  = 0;
	logic [7:0]    limit_copy = OUT_LIMIT_RST;
	line_item_t    pending_chars [$];

	int err_count      = 0;
	int cycle_count    = 0;
	bit no_idle        = 1'b0;
	int hold_req_count = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int stall_left     = 0;

	// Clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_space_class(input logic [BW-1:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic void flag_error(input string what, input logic [BW-1:0] want,
		input logic [BW-1:0] got);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// Edit the shadow line; a terminator queues the trimmed characters
	function automatic void apply_rx_byte(input logic [BW-1:0] c);
		int unsigned len;
		int unsigned first;
		int unsigned stop;
		line_item_t  li;
		if ((c == CH_CR) || (c == CH_LF)) begin
			if (fill_copy == 0) begin
				return;
			end
			len = 0;
			while ((len < fill_copy) && (line_copy[len] != CH_NUL)) begin
				len++;
			end
			if (len > limit_copy) begin
				len = limit_copy;
			end
			first = 0;
			while ((first < len) && is_space_class(line_copy[first])) begin
				first++;
			end
			stop = len;
			while ((stop > first) && is_space_class(line_copy[stop-1])) begin
				stop--;
			end
			fill_copy = 0;
			if (stop == first) begin
				li.ch    = '0;
				li.last  = 1'b1;
				li.empty = 1'b1;
				pending_chars.push_back(li);
			end else begin
				for (int unsigned i = first; i < stop; i++) begin
					li.ch    = line_copy[i];
					li.last  = (i + 1 == stop);
					li.empty = 1'b0;
					pending_chars.push_back(li);
				end
			end
		end else if ((c == CH_BS) || (c == CH_DEL)) begin
			if (fill_copy > 0) begin
				fill_copy--;
			end
		end else if (fill_copy < DEPTH - 1) begin
			line_copy[fill_copy] = c;
			fill_copy++;
		end
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Track accepted bytes and check each line item against the oldest expectation
	always @(posedge clk) begin
		line_item_t want;
		if (arst_n) begin
			if (line_ch.valid && line_ch.ready) begin
				if (pending_chars.size() == 0) begin
					flag_error("line item with none expected", '0, line_ch.line_char);
				end else begin
					want = pending_chars.pop_front();
					if (line_ch.line_empty !== want.empty) begin
						flag_error("line_empty", BW'(want.empty), BW'(line_ch.line_empty));
					end
					if (line_ch.line_last !== want.last) begin
						flag_error("line_last", BW'(want.last), BW'(line_ch.line_last));
					end
					if (!want.empty && (line_ch.line_char !== want.ch)) begin
						flag_error("line_char", want.ch, line_ch.line_char);
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				apply_rx_byte(rx_ch.rx_byte);
			end
		end
	end

	// Line receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req_count != hold_seen) begin
			hold_seen     <= hold_req_count;
			hold_left     <= HOLD_CYCLES - 1;
			line_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			line_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			line_ch.ready <= 1'b0;
		end else if (!no_idle && ($urandom_range(0, 4) == 0)) begin
			stall_left    <= idle_len() - 1;
			line_ch.ready <= 1'b0;
		end else begin
			line_ch.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [BW-1:0] b);
		int gap;
		gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
	endtask

	// Stop offering, wait for every queued item, then let the block go idle
	task automatic settle_idle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer, select left high so another can follow at once
	task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
		input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic write_out_limit(input logic [7:0] lim);
		logic [CFG_DW-1:0] rd;
		settle_idle();
		apb_xfer(1'b1, OUT_LIMIT_ADDR, CFG_DW'(lim), rd);
		apb_xfer(1'b0, OUT_LIMIT_ADDR, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[7:0] !== lim) begin
			flag_error("out_limit readback", lim, rd[7:0]);
		end
		limit_copy = lim;
	endtask

	function automatic logic [BW-1:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// Line text: mostly printable, some blanks, erases, zeros and raw bytes
	function automatic logic [BW-1:0] rand_text_byte();
		int            r;
		logic [BW-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return BW'($urandom_range(8'h21, 8'h7e));
		end else if (r < 78) begin
			return rand_blank();
		end else if (r < 86) begin
			return $urandom_range(0, 1) ? CH_BS : CH_DEL;
		end else if (r < 90) begin
			return CH_NUL;
		end
		c = BW'($urandom_range(0, 255));
		return ((c == CH_CR) || (c == CH_LF)) ? ~c : c;
	endfunction

	// A padded line with its terminator, or now and then a burst of raw bytes
	task automatic send_random_line(output int count);
		int n_pre;
		int n_body;
		int n_post;
		count = 0;
		if ($urandom_range(0, 99) < 15) begin
			n_body = $urandom_range(1, 6);
			repeat (n_body) send_byte(BW'($urandom_range(0, 255)));
			count = n_body;
			return;
		end
		n_pre  = $urandom_range(0, 2);
		n_post = $urandom_range(0, 2);
		n_body = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 14) : $urandom_range(15, 40);
		repeat (n_pre) send_byte(rand_blank());
		repeat (n_body) send_byte(rand_text_byte());
		repeat (n_post) send_byte(rand_blank());
		send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
		count = n_pre + n_body + n_post + 1;
	endtask

	task automatic test_reset_value();
		logic [CFG_DW-1:0] rd;
		apb_xfer(1'b0, OUT_LIMIT_ADDR, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[7:0] !== OUT_LIMIT_RST) begin
			flag_error("out_limit after reset", OUT_LIMIT_RST, rd[7:0]);
		end
	endtask

	// Ignored terminator and erase, trim, erase mid-line, zero cut, blank line
	task automatic test_edit_ops();
		logic [BW-1:0] seq [] = '{
			CH_LF, CH_BS, CH_SP, "A", "x", CH_BS, 8'hFF, CH_TAB, CH_CR,
			"B", CH_NUL, "C", CH_LF,
			CH_SP, CH_VT, CH_FF, CH_CR,
			"q", CH_DEL, CH_DEL, CH_LF,
			"z", 8'h80, CH_CR
		};
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// Limit zero blanks any line; small limits cut before the trim
	task automatic test_limit_cut();
		write_out_limit(8'd0);
		send_byte("a");
		send_byte("b");
		send_byte(CH_CR);
		write_out_limit(8'd1);
		send_byte(CH_SP);
		send_byte("k");
		send_byte(CH_CR);
		write_out_limit(8'd2);
		send_byte("p");
		send_byte("q");
		send_byte("r");
		send_byte(CH_LF);
	endtask

	// Overfill the buffer so extra bytes are dropped, then one full-length line
	task automatic test_full_store();
		write_out_limit(8'd254);
		repeat (66) send_byte(BW'($urandom_range(8'h21, 8'h7e)));
		send_byte(CH_DEL);
		send_byte("Z");
		send_byte(CH_CR);
	endtask

	task automatic test_random_lines(input logic [7:0] lim, input int budget,
		input bit back_to_back);
		int sent;
		int n;
		write_out_limit(lim);
		no_idle = back_to_back;
		sent    = 0;
		while (sent < budget) begin
			send_random_line(n);
			sent += n;
		end
		no_idle = 1'b0;
	endtask

	// Receiver held off while bytes keep coming until the input stalls
	task automatic test_backpressure();
		int sent;
		int n;
		write_out_limit(OUT_LIMIT_RST);
		no_idle = 1'b1;
		hold_req_count++;
		// a two-character line fills the output and blocks the input
		send_byte("h");
		send_byte("i");
		send_byte(CH_CR);
		sent = 0;
		while (sent < 6) begin
			send_random_line(n);
			sent += n;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_edit_ops();
		test_limit_cut();
		test_full_store();
		test_random_lines(8'd254, 12, 1'b0);
		test_random_lines(8'd5, 8, 1'b0);
		test_random_lines(OUT_LIMIT_RST, 8, 1'b1);
		test_backpressure();
		test_random_lines(8'd0, 4, 1'b0);
		test_random_lines(8'd20, 8, 1'b0);
		settle_idle();

		if ((err_count == 0) && (pending_chars.size() == 0)) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
